@@ design/ckm_pkg.sv @@
// Shared types, constants and a helper function of the caseless keyword matcher.
package ckm_pkg;

    localparam int CHAR_W          = 8;
    localparam int KW_REG_W        = 64;
    localparam int KW_CHARS_PER_REG = KW_REG_W / CHAR_W;
    localparam int LEN_W           = 5;
    localparam int MAX_KEYWORD_DEF = 16;
    localparam int CFG_IDX_W       = 2;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KW_LOW  = 2'd0,
        CFG_KW_HIGH = 2'd1,
        CFG_KW_LEN  = 2'd2
    } t_cfg_index;

    // Per-item control broadcast to every cell of the row
    typedef struct packed {
        logic adv;    // an item is accepted this cycle
        logic clear;  // drop all partial matches instead of storing them
    } t_cell_ctrl;

    // Fold ASCII upper-case letters to lower case; other bytes pass unchanged
    function automatic logic [CHAR_W-1:0] fold_char(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] r;
        r = c;
        if (c >= 8'h41 && c <= 8'h5A) begin
            r = c + 8'h20;
        end
        return r;
    endfunction

endpackage

@@ design/ckm_in_if.sv @@
// Input channel: one text character per item with its end-of-string flag.
interface ckm_in_if import ckm_pkg::*;;
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] text_char;
    logic              end_of_text;

    modport source (output valid, output text_char, output end_of_text, input ready);
    modport sink   (input valid, input text_char, input end_of_text, output ready);
endinterface

@@ design/ckm_out_if.sv @@
// Output channel: one match result per item.
interface ckm_out_if;
    logic valid;
    logic ready;
    logic match_end;
    logic string_done;
    logic keyword_found;

    modport source (output valid, output match_end, output string_done,
                    output keyword_found, input ready);
    modport sink   (input valid, input match_end, input string_done,
                    input keyword_found, output ready);
endinterface

@@ design/ckm_cell.sv @@
// One matcher cell: holds one bit of the shift-and partial-match vector.
module ckm_cell import ckm_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cell_ctrl        i_ctrl,
    input  logic              i_active,
    input  logic [CHAR_W-1:0] i_kw_char,
    input  logic [CHAR_W-1:0] i_text_char,
    input  logic              i_prev,
    output logic              o_cand,
    output logic              o_bit
);

    logic r_bit;
    logic n_bit;
    logic w_eq;

    // Compare the folded keyword character with the folded text character
    assign w_eq   = (fold_char(i_kw_char) == i_text_char);
    assign o_cand = i_prev && w_eq && i_active;

    // Store the candidate unless a match or end of string clears the row
    always_comb begin
        n_bit = r_bit;
        if (i_ctrl.adv) begin
            n_bit = o_cand && !i_ctrl.clear;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit <= 1'b0;
        end else begin
            r_bit <= n_bit;
        end
    end

    assign o_bit = r_bit;

endmodule

@@ design/caseless_keyword_matcher.sv @@
// Top level of the caseless keyword matcher: config registers, cell row, result register.
// The block takes one character per clock while the output is not stalled and gives one
// result per character, in the cycle after the character is accepted; a full row of cells,
// one per keyword character, updates the partial-match vector in a single step, and the
// output register lets a new character enter while the previous result waits, so the input
// is ready whenever the result register is empty or is being emptied. A keyword of length
// zero always reports found with no match marks. Write the keyword and its length through
// the configuration port only while no item is in flight; the block does not enforce it.
module caseless_keyword_matcher import ckm_pkg::*; #(
    parameter int MAX_KEYWORD = MAX_KEYWORD_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [KW_REG_W-1:0]  i_cfg_data,
    ckm_in_if.sink               i_text,
    ckm_out_if.source            o_result
);

    logic [KW_REG_W-1:0]   r_kw_low;
    logic [KW_REG_W-1:0]   r_kw_high;
    logic [LEN_W-1:0]      r_kw_len;
    logic [2*KW_REG_W-1:0] w_kw_chars;
    logic [LEN_W-1:0]      w_len_act;

    logic                  w_accept;
    logic [CHAR_W-1:0]     w_char;
    logic [MAX_KEYWORD-1:0] w_cand;
    logic [MAX_KEYWORD-1:0] w_vec;
    logic                  w_match;
    logic                  w_found_now;
    t_cell_ctrl            w_ctrl;

    logic r_found;
    logic n_found;
    logic r_ovalid;
    logic r_match_end;
    logic r_string_done;
    logic r_keyword_found;

    // Hold the configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kw_low  <= '0;
            r_kw_high <= '0;
            r_kw_len  <= '0;
        end else if (i_cfg_wr_en) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_KW_LOW:  r_kw_low  <= i_cfg_data;
                CFG_KW_HIGH: r_kw_high <= i_cfg_data;
                CFG_KW_LEN:  r_kw_len  <= i_cfg_data[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    assign w_kw_chars = {r_kw_high, r_kw_low};
    // Clamp an overlong keyword length to the row size
    assign w_len_act  = (r_kw_len > LEN_W'(MAX_KEYWORD)) ? LEN_W'(MAX_KEYWORD) : r_kw_len;

    // Handshake: take an item whenever the result register is free or draining
    assign i_text.ready = !r_ovalid || o_result.ready;
    assign w_accept     = i_text.valid && i_text.ready;
    assign w_char       = fold_char(i_text.text_char);

    // Row of cells, each fed by its left neighbor; cell 0 always starts a prefix
    for (genvar g = 0; g < MAX_KEYWORD; g++) begin : g_cell
        logic w_prev;
        if (g == 0) begin : g_head
            assign w_prev = 1'b1;
        end else begin : g_body
            assign w_prev = w_vec[g-1];
        end
        ckm_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctrl      (w_ctrl),
            .i_active    (w_len_act > LEN_W'(g)),
            .i_kw_char   (w_kw_chars[CHAR_W*g +: CHAR_W]),
            .i_text_char (w_char),
            .i_prev      (w_prev),
            .o_cand      (w_cand[g]),
            .o_bit       (w_vec[g])
        );
    end

    // Full match when the cell at the last keyword position fires
    always_comb begin
        w_match = 1'b0;
        for (int i = 0; i < MAX_KEYWORD; i++) begin
            if (w_cand[i] && (w_len_act == LEN_W'(i + 1))) begin
                w_match = 1'b1;
            end
        end
    end

    assign w_ctrl.adv   = w_accept;
    assign w_ctrl.clear = w_match || i_text.end_of_text;

    assign w_found_now = (w_len_act == '0) || r_found || w_match;

    // Track whether the current string has matched; drop at end of string
    always_comb begin
        n_found = r_found;
        if (w_accept) begin
            n_found = i_text.end_of_text ? 1'b0 : (r_found || w_match);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else begin
            r_found <= n_found;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_accept) begin
            r_ovalid <= 1'b1;
        end else if (o_result.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_match_end     <= w_match;
            r_string_done   <= i_text.end_of_text;
            r_keyword_found <= w_found_now;
        end
    end

    assign o_result.valid         = r_ovalid;
    assign o_result.match_end     = r_match_end;
    assign o_result.string_done   = r_string_done;
    assign o_result.keyword_found = r_keyword_found;

    // A marked match always reports the keyword as found
    a_match_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid && o_result.match_end |-> o_result.keyword_found)
        else $error("match_end without keyword_found");

    // End of string leaves no partial match and no found flag behind
    a_eos_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && i_text.end_of_text |=> (w_vec == '0) && !r_found)
        else $error("state not cleared after end of string");

    // A full match restarts the search with an empty vector
    a_match_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && w_match |=> (w_vec == '0))
        else $error("partial matches kept after a full match");

endmodule
